[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros
// shared property wrappers for the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define CDO_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define CDO_NEVER(lbl, clk, rst_n, expr, msg) \
    `CDO_ASSERT(lbl, clk, rst_n, !(expr), msg)

`endif

[hdl/cdo_pkg.sv]
// ---------------------------------------------------------------------------
// cdo_pkg
// widths, calendar constants and month length helpers for the date offset block
// ---------------------------------------------------------------------------
package cdo_pkg;

    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int OFFSET_W = 18;
    localparam int SERIAL_W = 17;
    localparam int ACC_W    = 19;
    localparam int YIDX_W   = 8;

    localparam logic [YEAR_W-1:0]   FIRST_YEAR = 12'd1900;
    localparam logic [YEAR_W-1:0]   LAST_YEAR  = 12'd2099;
    localparam logic [SERIAL_W-1:0] SPAN_DAYS  = 17'd73049;
    localparam logic [MONTH_W-1:0]  LAST_MONTH = 4'd12;

    localparam logic signed [ACC_W-1:0] ACC_SPAN     = 19'sd73049;
    localparam logic signed [ACC_W-1:0] ACC_YEAR     = 19'sd365;
    localparam logic signed [ACC_W-1:0] ACC_LEAP     = 19'sd366;
    localparam logic signed [ACC_W-1:0] ACC_ONE      = 19'sd1;

    // year index counts from the first year; inside the span every fourth
    // year is leap except the first one (2000 is leap, 2100 lies outside)
    function automatic logic is_leap_idx(input logic [YIDX_W-1:0] idx);
        logic leap;
        leap = (idx[1:0] == 2'b00) && (idx != '0);
        return leap;
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic leap,
                                                     input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] n;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     n = 5'd30;
            4'd2:                                        n = leap ? 5'd29 : 5'd28;
            default:                                     n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

[hdl/calendar_date_offset_top.sv]
// ---------------------------------------------------------------------------
// calendar_date_offset_top
// date to serial day count, signed day offset with wrap, serial back to date
// ---------------------------------------------------------------------------
// the result waits on the year and month walks over one shared 19-bit adder
// (up to 199 years and 11 months each way)
// throughput: one transaction at a time, next accepted the cycle after the
// result moves to the output register
// reset: asynchronous active low, clears sequencer and output valid only
module calendar_date_offset_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [cdo_pkg::YEAR_W-1:0]        in_year,
    input  logic [cdo_pkg::MONTH_W-1:0]       in_month,
    input  logic [cdo_pkg::DAY_W-1:0]         in_day,
    input  logic signed [cdo_pkg::OFFSET_W-1:0] offset_days,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic                              date_was_valid,
    output logic [cdo_pkg::SERIAL_W-1:0]      start_serial,
    output logic [cdo_pkg::SERIAL_W-1:0]      result_serial,
    output logic [cdo_pkg::YEAR_W-1:0]        out_year,
    output logic [cdo_pkg::MONTH_W-1:0]       out_month,
    output logic [cdo_pkg::DAY_W-1:0]         out_day
);
    import cdo_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_YACC = 9'b000000010,
        ST_MACC = 9'b000000100,
        ST_DACC = 9'b000001000,
        ST_OFFS = 9'b000010000,
        ST_WRAP = 9'b000100000,
        ST_YSUB = 9'b001000000,
        ST_MSUB = 9'b010000000,
        ST_DONE = 9'b100000000
    } state_t;

    state_t                      state_reg, state_next;
    logic signed [ACC_W-1:0]     acc_reg, acc_next;
    logic [YIDX_W-1:0]           cnt_reg, cnt_next;
    logic [MONTH_W-1:0]          mcnt_reg, mcnt_next;
    logic [YIDX_W-1:0]           ytgt_reg;
    logic [MONTH_W-1:0]          mtgt_reg;
    logic [DAY_W-1:0]            dofs_reg;
    logic signed [OFFSET_W-1:0]  off_reg;
    logic                        ok_reg;
    logic [SERIAL_W-1:0]         start_reg, start_next;
    logic [SERIAL_W-1:0]         res_reg, res_next;
    logic                        rsp_valid_reg;

    logic                        req_fire;
    logic                        rsp_fire;
    logic                        out_load;
    logic [YEAR_W-1:0]           year_off;
    logic                        in_leap;
    logic                        date_ok;
    logic                        cnt_leap;
    logic                        tgt_leap;
    logic [DAY_W-1:0]            dim;
    logic signed [ACC_W-1:0]     dim_ext;
    logic signed [ACC_W-1:0]     opnd;
    logic signed [ACC_W-1:0]     acc_sum;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign rsp_fire  = rsp_valid_reg && !rsp_stall;
    assign out_load  = (state_reg == ST_DONE) && (!rsp_valid_reg || !rsp_stall);

    // input date check
    assign year_off = in_year - FIRST_YEAR;
    assign in_leap  = is_leap_idx(year_off[YIDX_W-1:0]);
    assign date_ok  = (in_year >= FIRST_YEAR) && (in_year <= LAST_YEAR) &&
                      (in_month != '0) && (in_month <= LAST_MONTH) &&
                      (in_day != '0) && (in_day <= month_days(in_leap, in_month));

    // shared adder and its operand select
    assign cnt_leap = is_leap_idx(cnt_reg);
    assign tgt_leap = is_leap_idx(ytgt_reg);
    assign dim      = month_days((state_reg == ST_MACC) ? tgt_leap : cnt_leap, mcnt_reg);
    assign dim_ext  = signed'({{(ACC_W-DAY_W){1'b0}}, dim});
    assign acc_sum  = acc_reg + opnd;

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        mcnt_next  = mcnt_reg;
        start_next = start_reg;
        res_next   = res_reg;
        opnd       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    acc_next   = '0;
                    cnt_next   = '0;
                    mcnt_next  = MONTH_W'(1);
                    state_next = ST_YACC;
                end
            end
            ST_YACC:
            begin
                opnd = cnt_leap ? ACC_LEAP : ACC_YEAR;
                if (cnt_reg < ytgt_reg)
                begin
                    acc_next = acc_sum;
                    cnt_next = cnt_reg + YIDX_W'(1);
                end
                else
                begin
                    state_next = ST_MACC;
                end
            end
            ST_MACC:
            begin
                opnd = dim_ext;
                if (mcnt_reg < mtgt_reg)
                begin
                    acc_next  = acc_sum;
                    mcnt_next = mcnt_reg + MONTH_W'(1);
                end
                else
                begin
                    state_next = ST_DACC;
                end
            end
            ST_DACC:
            begin
                opnd       = signed'({{(ACC_W-DAY_W){1'b0}}, dofs_reg});
                acc_next   = acc_sum;
                state_next = ST_OFFS;
            end
            ST_OFFS:
            begin
                opnd       = ACC_W'(off_reg);
                start_next = acc_reg[SERIAL_W-1:0];
                acc_next   = acc_sum;
                state_next = ST_WRAP;
            end
            ST_WRAP:
            begin
                if (acc_reg[ACC_W-1])
                begin
                    opnd     = ACC_SPAN;
                    acc_next = acc_sum;
                end
                else if (acc_reg >= ACC_SPAN)
                begin
                    opnd     = -ACC_SPAN;
                    acc_next = acc_sum;
                end
                else
                begin
                    opnd       = ACC_ONE;
                    res_next   = acc_reg[SERIAL_W-1:0];
                    acc_next   = acc_sum;
                    cnt_next   = '0;
                    state_next = ST_YSUB;
                end
            end
            ST_YSUB:
            begin
                opnd = cnt_leap ? -ACC_LEAP : -ACC_YEAR;
                if ((acc_reg > ACC_YEAR) && (!cnt_leap || (acc_reg > ACC_LEAP)))
                begin
                    acc_next = acc_sum;
                    cnt_next = cnt_reg + YIDX_W'(1);
                end
                else
                begin
                    mcnt_next  = MONTH_W'(1);
                    state_next = ST_MSUB;
                end
            end
            ST_MSUB:
            begin
                opnd = -dim_ext;
                if ((mcnt_reg < LAST_MONTH) && (acc_reg > dim_ext))
                begin
                    acc_next  = acc_sum;
                    mcnt_next = mcnt_reg + MONTH_W'(1);
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_fire)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        cnt_reg   <= cnt_next;
        mcnt_reg  <= mcnt_next;
        start_reg <= start_next;
        res_reg   <= res_next;
        if (req_fire)
        begin
            ok_reg   <= date_ok;
            ytgt_reg <= date_ok ? year_off[YIDX_W-1:0] : '0;
            mtgt_reg <= date_ok ? in_month : MONTH_W'(1);
            dofs_reg <= date_ok ? (in_day - DAY_W'(1)) : '0;
            off_reg  <= offset_days;
        end
        if (out_load)
        begin
            date_was_valid <= ok_reg;
            start_serial   <= start_reg;
            result_serial  <= res_reg;
            out_year       <= FIRST_YEAR + {{(YEAR_W-YIDX_W){1'b0}}, cnt_reg};
            out_month      <= mcnt_reg;
            out_day        <= acc_reg[DAY_W-1:0];
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

[hdl/cdo_checker.sv]
// ---------------------------------------------------------------------------
// cdo_checker
// port level checks for the date offset block, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cdo_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              req_valid,
    input logic                              req_stall,
    input logic                              rsp_valid,
    input logic                              rsp_stall,
    input logic                              date_was_valid,
    input logic [cdo_pkg::SERIAL_W-1:0]      start_serial,
    input logic [cdo_pkg::SERIAL_W-1:0]      result_serial,
    input logic [cdo_pkg::MONTH_W-1:0]       out_month,
    input logic [cdo_pkg::DAY_W-1:0]         out_day
);
    import cdo_pkg::*;

    // stalled result transaction holds
    `CDO_ASSERT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall |=> rsp_valid && $stable(result_serial) && $stable(start_serial), "stalled result changed")
    // an accepted transaction keeps the sequencer busy next cycle
    `CDO_ASSERT(a_busy_after_accept, clk, rst_n, req_valid && !req_stall |=> req_stall, "input not stalled after accept")
    // start and wrapped result serials stay inside the span
    `CDO_NEVER(a_serial_range, clk, rst_n, rsp_valid && (result_serial >= SPAN_DAYS || start_serial >= SPAN_DAYS), "serial out of span")
    // replaced date starts at serial zero
    `CDO_NEVER(a_invalid_start, clk, rst_n, rsp_valid && !date_was_valid && (start_serial != '0), "invalid date has nonzero start serial")
    // result date fields are legal
    `CDO_NEVER(a_date_fields, clk, rst_n, rsp_valid && (out_month == '0 || out_month > LAST_MONTH || out_day == '0), "illegal result date")

endmodule

bind calendar_date_offset_top cdo_checker u_cdo_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .date_was_valid (date_was_valid),
    .start_serial   (start_serial),
    .result_serial  (result_serial),
    .out_month      (out_month),
    .out_day        (out_day)
);
